@@ rtl/core/cpc_pkg.sv @@
// Package: shared widths, power-of-ten table and control/status structs.
`timescale 1ns / 1ps
package cpc_pkg;

  localparam int VALUE_W        = 20;  // input value width
  localparam int NUM_W          = 24;  // rotated values stay below 10^7
  localparam int DIV_W          = 13;  // trial divisor, up to sqrt(2^24)
  localparam int REM_W          = DIV_W + 1;
  localparam int SQ_W           = 2 * DIV_W;
  localparam int BCNT_W         = 5;   // counts NUM_W divider steps
  localparam int DIG_W          = 4;   // digit count and rotation index
  localparam int DEF_MAX_DIGITS = 6;

  // 10^k for the digit counter and the rotation top digit
  function automatic logic [NUM_W-1:0] pow10(input logic [DIG_W-1:0] k);
    logic [NUM_W-1:0] r;
    case (k)
      4'd0:    r = NUM_W'(1);
      4'd1:    r = NUM_W'(10);
      4'd2:    r = NUM_W'(100);
      4'd3:    r = NUM_W'(1000);
      4'd4:    r = NUM_W'(10000);
      4'd5:    r = NUM_W'(100000);
      4'd6:    r = NUM_W'(1000000);
      4'd7:    r = NUM_W'(10000000);
      default: r = '1;
    endcase
    return r;
  endfunction

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture new input value
    logic prime_init;  // divisor = 2, square = 4
    logic div_start;   // start a remainder computation
    logic div_step;    // one restoring-divide bit
    logic next_div;    // advance divisor and its square
    logic cnt_step;    // one digit-count compare
    logic lead_step;   // strip one unit of the leading digit
    logic rot_finish;  // shift left one digit, append lead
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic lt2;
    logic sq_gt;
    logic div_done;
    logic rem_zero;
    logic cnt_done;
    logic too_long;
    logic rot_last;
    logic lead_done;
  } sts_t;

endpackage

@@ rtl/core/cpc_if.sv @@
// Interfaces: input and result channels with valid/ready handshake.
`timescale 1ns / 1ps
interface cpc_in_if import cpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface cpc_out_if ();
  logic valid;
  logic ready;
  logic prime_flag;
  logic circular_flag;
  modport source (output valid, output prime_flag, output circular_flag, input ready);
  modport sink   (input valid, input prime_flag, input circular_flag, output ready);
endinterface

@@ rtl/core/circular_prime_checker.sv @@
// Top level: circular prime checker, controller plus datapath.
//
// Usage: one beat on in_if carries a 20-bit value; one beat on out_if
// returns prime_flag (value is prime) and circular_flag (value is prime
// and every left rotation of its decimal digits is prime; a zero that
// rotates to the front stays a digit). Values with more digits than
// MAX_DIGITS report circular_flag = 0.
// One value is in flight at a time: in_if.ready is high only while the
// block is idle. Each primality test runs trial divisors d = 2, 3, ...
// while d*d <= n through one bit-serial restoring divider of 24 steps
// per divisor. A full circular check adds one test per rotation, a
// digit count and, per rotation, repeated subtraction to move the top digit.
// The result sits in an output register and holds while out_if.ready is
// low; no new value is taken until it is delivered.
// Reset (rst_n low, synchronous) returns the block to idle and drops
// out_if.valid.
`timescale 1ns / 1ps
module circular_prime_checker import cpc_pkg::*; #(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input logic      clk,
  input logic      rst_n,
  cpc_in_if.sink   in_if,
  cpc_out_if.source out_if
);

  cmd_t cmd;
  sts_t sts;

  cpc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_ready     (in_if.ready),
    .out_valid    (out_if.valid),
    .out_ready    (out_if.ready),
    .out_prime    (out_if.prime_flag),
    .out_circular (out_if.circular_flag),
    .sts          (sts),
    .cmd          (cmd)
  );

  cpc_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk      (clk),
    .in_value (in_if.value),
    .cmd      (cmd),
    .sts      (sts)
  );

  // a circular result always implies a prime result
  a_circ_prime: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.prime_flag || !out_if.circular_flag))
    else $error("circular flag without prime flag");

  // one item at a time: never ready while a result is pending
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_if.ready && out_if.valid))
    else $error("input ready while result pending");

  // an accepted beat takes the block out of idle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("still ready after accepting a beat");

endmodule

@@ rtl/core/cpc_datapath.sv @@
// Datapath: value registers, serial divider, divisor/square, digit logic.
`timescale 1ns / 1ps
module cpc_datapath import cpc_pkg::*; #(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic               clk,
  input  logic [VALUE_W-1:0] in_value,
  input  cmd_t               cmd,
  output sts_t               sts
);

  logic [NUM_W-1:0]  t_r, t_nxt;      // number under test
  logic [NUM_W-1:0]  v_r, v_nxt;      // original value
  logic [DIV_W-1:0]  d_r, d_nxt;
  logic [SQ_W-1:0]   sq_r, sq_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  q_r, q_nxt;      // dividend shift register
  logic [BCNT_W-1:0] bcnt_r, bcnt_nxt;
  logic [DIG_W-1:0]  dig_r, dig_nxt;
  logic [DIG_W-1:0]  rot_r, rot_nxt;
  logic [DIG_W-1:0]  lead_r, lead_nxt;

  logic [REM_W-1:0]  rem_sh;
  logic [NUM_W-1:0]  top;
  logic [NUM_W-1:0]  dig_pow;

  assign rem_sh  = {rem_r[REM_W-2:0], q_r[NUM_W-1]};
  assign top     = pow10(dig_r - DIG_W'(1));
  assign dig_pow = pow10(dig_r);

  // next-state selection
  always_comb begin
    t_nxt    = t_r;
    v_nxt    = v_r;
    d_nxt    = d_r;
    sq_nxt   = sq_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    bcnt_nxt = bcnt_r;
    dig_nxt  = dig_r;
    rot_nxt  = rot_r;
    lead_nxt = lead_r;
    if (cmd.load) begin
      t_nxt    = NUM_W'(in_value);
      v_nxt    = NUM_W'(in_value);
      dig_nxt  = '0;
      rot_nxt  = '0;
      lead_nxt = '0;
    end
    if (cmd.prime_init) begin
      d_nxt  = DIV_W'(2);
      sq_nxt = SQ_W'(4);
    end
    if (cmd.div_start) begin
      q_nxt    = t_r;
      rem_nxt  = '0;
      bcnt_nxt = BCNT_W'(NUM_W);
    end
    // restoring division, one quotient bit per beat of the loop
    if (cmd.div_step) begin
      q_nxt    = {q_r[NUM_W-2:0], 1'b0};
      bcnt_nxt = bcnt_r - BCNT_W'(1);
      if (rem_sh >= REM_W'(d_r))
        rem_nxt = rem_sh - REM_W'(d_r);
      else
        rem_nxt = rem_sh;
    end
    // (d+1)^2 = d^2 + 2d + 1
    if (cmd.next_div) begin
      d_nxt  = d_r + DIV_W'(1);
      sq_nxt = sq_r + SQ_W'({d_r, 1'b0}) + SQ_W'(1);
    end
    if (cmd.cnt_step)
      dig_nxt = dig_r + DIG_W'(1);
    if (cmd.lead_step) begin
      t_nxt    = t_r - top;
      lead_nxt = lead_r + DIG_W'(1);
    end
    // t*10 + lead
    if (cmd.rot_finish) begin
      t_nxt    = (t_r << 3) + (t_r << 1) + NUM_W'(lead_r);
      lead_nxt = '0;
      rot_nxt  = rot_r + DIG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    t_r    <= t_nxt;
    v_r    <= v_nxt;
    d_r    <= d_nxt;
    sq_r   <= sq_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    bcnt_r <= bcnt_nxt;
    dig_r  <= dig_nxt;
    rot_r  <= rot_nxt;
    lead_r <= lead_nxt;
  end

  // status
  assign sts.lt2       = (t_r < NUM_W'(2));
  assign sts.sq_gt     = (sq_r > SQ_W'(t_r));
  assign sts.div_done  = (bcnt_r == '0);
  assign sts.rem_zero  = (rem_r == '0);
  assign sts.cnt_done  = (dig_r == DIG_W'(8)) || (v_r < dig_pow);
  assign sts.too_long  = (dig_r > DIG_W'(MAX_DIGITS));
  assign sts.rot_last  = (rot_r == dig_r - DIG_W'(1));
  assign sts.lead_done = (t_r < top);

endmodule

@@ rtl/core/cpc_ctrl.sv @@
// Controller: sequences primality tests over the value and its rotations.
`timescale 1ns / 1ps
module cpc_ctrl import cpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic out_prime,
  output logic out_circular,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_PINIT, S_PCHK, S_DIV, S_CNT, S_RCHK, S_LEAD, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   rot_phase_r, rot_phase_nxt;  // 0: original value, 1: a rotation
  logic   prime_r, prime_nxt;
  logic   circ_r, circ_nxt;
  logic   valid_r, valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    rot_phase_nxt = rot_phase_r;
    prime_nxt     = prime_r;
    circ_nxt      = circ_r;
    valid_nxt     = valid_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load      = 1'b1;
          rot_phase_nxt = 1'b0;
          state_nxt     = S_PINIT;
        end
      end
      S_PINIT: begin
        cmd.prime_init = 1'b1;
        state_nxt      = S_PCHK;
      end
      S_PCHK: begin
        if (sts.lt2) begin
          // not prime
          if (!rot_phase_r) prime_nxt = 1'b0;
          circ_nxt  = 1'b0;
          valid_nxt = 1'b1;
          state_nxt = S_OUT;
        end else if (sts.sq_gt) begin
          // prime
          if (!rot_phase_r) begin
            prime_nxt     = 1'b1;
            rot_phase_nxt = 1'b1;
            state_nxt     = S_CNT;
          end else begin
            state_nxt = S_RCHK;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            if (!rot_phase_r) prime_nxt = 1'b0;
            circ_nxt  = 1'b0;
            valid_nxt = 1'b1;
            state_nxt = S_OUT;
          end else begin
            cmd.next_div = 1'b1;
            state_nxt    = S_PCHK;
          end
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_CNT: begin
        if (sts.cnt_done) begin
          if (sts.too_long) begin
            circ_nxt  = 1'b0;
            valid_nxt = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_RCHK;
          end
        end else begin
          cmd.cnt_step = 1'b1;
        end
      end
      S_RCHK: begin
        if (sts.rot_last) begin
          circ_nxt  = 1'b1;
          valid_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_LEAD;
        end
      end
      S_LEAD: begin
        if (sts.lead_done) begin
          cmd.rot_finish = 1'b1;
          state_nxt      = S_PINIT;
        end else begin
          cmd.lead_step = 1'b1;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          valid_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= 1'b0;
      rot_phase_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      rot_phase_r <= rot_phase_nxt;
    end
    prime_r <= prime_nxt;
    circ_r  <= circ_nxt;
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = valid_r;
  assign out_prime    = prime_r;
  assign out_circular = circ_r;

endmodule

@@ bench/tb_circular_prime_checker.sv @@
// Testbench for circular_prime_checker: random and directed values with a self-checking scoreboard.
`timescale 1ns / 1ps
module tb_circular_prime_checker;
  import cpc_pkg::*;

  localparam int MAX_DIG = DEF_MAX_DIGITS;

  typedef struct packed {
    logic prime_flag;
    logic circular_flag;
  } flags_t;

  // Scoreboard: predicts the flags of each accepted value and checks each result
  class primality_scoreboard;
    flags_t pending_flags[$];
    int     error_count = 0;
    int     result_count = 0;

    function bit prime_by_trial(longint unsigned n);
      longint unsigned d;
      if (n < 2) return 0;
      for (d = 2; d * d <= n; d++)
        if (n % d == 0) return 0;
      return 1;
    endfunction

    // every left digit rotation prime; leading zeros stay as digits
    function bit rotations_prime(longint unsigned n);
      longint unsigned t, lead, top;
      int digits;
      digits = 0;
      t = n;
      top = 1;
      while (t > 0) begin
        digits++;
        t = t / 10;
      end
      if (digits > MAX_DIG) return 0;
      for (int k = 1; k < digits; k++) top = top * 10;
      t = n;
      for (int k = 1; k < digits; k++) begin
        lead = t / top;
        t = (t % top) * 10 + lead;
        if (!prime_by_trial(t)) return 0;
      end
      return 1;
    endfunction

    function void note_value(logic [VALUE_W-1:0] v);
      flags_t f;
      f.prime_flag    = prime_by_trial(v);
      f.circular_flag = f.prime_flag && rotations_prime(v);
      pending_flags.push_back(f);
    endfunction

    function void check_flags(logic p, logic c);
      flags_t f;
      result_count++;
      if (pending_flags.size() == 0) begin
        $display("%0t: result beat with nothing pending (prime=%b circular=%b)", $time, p, c);
        error_count++;
        return;
      end
      f = pending_flags.pop_front();
      if (p !== f.prime_flag) begin
        $display("%0t: prime_flag mismatch, expected %b actual %b", $time, f.prime_flag, p);
        error_count++;
      end
      if (c !== f.circular_flag) begin
        $display("%0t: circular_flag mismatch, expected %b actual %b",
                 $time, f.circular_flag, c);
        error_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  cpc_in_if  in_ch ();
  cpc_out_if out_ch ();
  primality_scoreboard sb;

  circular_prime_checker uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #1_000_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Send one value; valid stays high across back-to-back beats
  task automatic send_value(logic [VALUE_W-1:0] v, int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_value(v);
  endtask

  // Receiver: random stalls, one long hold-off to back up the block
  task automatic drain_results();
    int stall;
    forever begin
      if (sb.result_count == 20) stall = 400;
      else if ((sb.result_count / 16) % 2 == 1) stall = 0;
      else stall = $urandom_range(0, 14);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_flags(out_ch.prime_flag, out_ch.circular_flag);
    end
  endtask

  function automatic int sender_gap(int idx);
    if ((idx / 12) % 3 == 2) return 0;
    return $urandom_range(0, 14);
  endfunction

  // Directed corners: small values, zero rotation, circular primes, too many digits
  logic [VALUE_W-1:0] directed_vals[] = '{
    20'd0, 20'd1, 20'd2, 20'd3, 20'd4, 20'd9, 20'd11, 20'd13, 20'd19, 20'd23,
    20'd101, 20'd103, 20'd113, 20'd197, 20'd199, 20'd1193, 20'd1009,
    20'd999983, 20'd999331, 20'd999999, 20'd1000003, 20'hFFFFF, 20'h55555, 20'hAAAAA
  };

  initial begin
    logic [VALUE_W-1:0] v;
    int sel;
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      drain_results();
    join_none

    foreach (directed_vals[i]) send_value(directed_vals[i], sender_gap(i));

    // mostly small values keep trial division short; a few large ones
    for (int i = 0; i < 76; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) v = VALUE_W'($urandom_range(0, 9999));
      else if (sel < 92) v = VALUE_W'($urandom_range(10000, 99999));
      else if (sel < 97) v = VALUE_W'($urandom_range(100000, 999999));
      else v = VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
      send_value(v, sender_gap(i));
    end
    in_ch.valid <= 1'b0;

    while (sb.pending_flags.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/cpc_pkg.sv
rtl/core/cpc_if.sv
rtl/core/cpc_datapath.sv
rtl/core/cpc_ctrl.sv
rtl/core/circular_prime_checker.sv
bench/tb_circular_prime_checker.sv
